// ===== rtl/nge_pkg.sv =====
// Shared constants, types and field map for the NMEA GGA/VTG field extractor.
package nge_pkg;

  localparam int LineLimit  = 128;
  localparam int RecordSize = 94;
  localparam int RecAddrW   = $clog2(RecordSize);
  localparam int CharPosW   = $clog2(LineLimit);

  typedef logic [RecAddrW-1:0] rec_addr_t;
  typedef logic [CharPosW-1:0] char_pos_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GGA  = 2'd1,
    KIND_VTG  = 2'd2
  } kind_e;

  localparam logic ActRx   = 1'b0;
  localparam logic ActRead = 1'b1;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChG       = 8'h47;
  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChV       = 8'h56;
  localparam logic [7:0] ChT       = 8'h54;

  localparam logic [15:0] HdrGg = {ChG, ChG};
  localparam logic [15:0] HdrVt = {ChV, ChT};

  typedef struct packed {
    rec_addr_t   base;
    logic [3:0]  cap;
  } field_slot_t;

  // Base and capacity of a field; capacity zero marks a field that is not stored.
  function automatic field_slot_t field_map(kind_e kind, logic [3:0] comma);
    field_slot_t s;
    s.base = '0;
    s.cap  = '0;
    if (kind == KIND_GGA) begin
      unique case (comma)
        4'd1:    begin s.base = RecAddrW'(0);  s.cap = 4'd11; end
        4'd2:    begin s.base = RecAddrW'(11); s.cap = 4'd10; end
        4'd3:    begin s.base = RecAddrW'(21); s.cap = 4'd2;  end
        4'd4:    begin s.base = RecAddrW'(23); s.cap = 4'd11; end
        4'd5:    begin s.base = RecAddrW'(34); s.cap = 4'd2;  end
        4'd6:    begin s.base = RecAddrW'(36); s.cap = 4'd2;  end
        4'd7:    begin s.base = RecAddrW'(38); s.cap = 4'd3;  end
        4'd9:    begin s.base = RecAddrW'(41); s.cap = 4'd11; end
        4'd10:   begin s.base = RecAddrW'(52); s.cap = 4'd2;  end
        default: begin s.base = '0;            s.cap = 4'd0;  end
      endcase
    end else if (kind == KIND_VTG) begin
      unique case (comma)
        4'd1:    begin s.base = RecAddrW'(78); s.cap = 4'd6;  end
        4'd2:    begin s.base = RecAddrW'(84); s.cap = 4'd2;  end
        4'd3:    begin s.base = RecAddrW'(86); s.cap = 4'd6;  end
        4'd4:    begin s.base = RecAddrW'(92); s.cap = 4'd2;  end
        4'd5:    begin s.base = RecAddrW'(54); s.cap = 4'd10; end
        4'd6:    begin s.base = RecAddrW'(64); s.cap = 4'd2;  end
        4'd7:    begin s.base = RecAddrW'(66); s.cap = 4'd10; end
        4'd8:    begin s.base = RecAddrW'(76); s.cap = 4'd2;  end
        default: begin s.base = '0;            s.cap = 4'd0;  end
      endcase
    end
    return s;
  endfunction

endpackage

// ===== rtl/nge_if.sv =====
// Valid/ready channel interfaces for the extractor input and result items.
interface nge_in_if;
  import nge_pkg::*;
  logic      valid;
  logic      ready;
  logic      action;
  logic [7:0] rx_byte;
  rec_addr_t read_addr;
  modport source (output valid, action, rx_byte, read_addr, input ready);
  modport sink   (input valid, action, rx_byte, read_addr, output ready);
endinterface

interface nge_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       sentence_done;
  logic [1:0] sentence_kind;
  modport source (output valid, read_data, sentence_done, sentence_kind, input ready);
  modport sink   (input valid, read_data, sentence_done, sentence_kind, output ready);
endinterface

// ===== rtl/nmea_gga_vtg_field_extractor.sv =====
// Top level: NMEA GGA/VTG sentence parser writing fields into a record memory.
// A result is valid in the cycle after its item is accepted (registered RAM read).
// Throughput: one item per cycle while result_o.ready is high; the record RAM takes one write and one read per cycle.
// Each received byte does at most one record write, so no read/write hazard arises.
// Reset: control state and per-entry valid bits clear at once; unwritten entries read as zero.
module nmea_gga_vtg_field_extractor (
  input  logic            clk_i,
  input  logic            rst_ni,
  nge_in_if.sink          item_i,
  nge_out_if.source       result_o
);
  import nge_pkg::*;

  logic [7:0]      mem [RecordSize];
  logic [RecordSize-1:0] vld_q;

  logic       in_sent_q, in_sent_d;
  char_pos_t  pos_q, pos_d;
  logic [15:0] hdr_q, hdr_d;
  kind_e      kind_q, kind_d;
  logic [3:0] comma_q, comma_d;
  logic [3:0] idx_q, idx_d;
  logic       closed_q, closed_d;

  logic       out_valid_q;
  logic       done_q, done_d;
  logic [1:0] okind_q, okind_d;
  logic       rd_ok_q;
  logic [7:0] rd_mem_q;

  logic       acc, rx;
  logic [7:0] c;
  logic [CharPosW:0] n;
  field_slot_t fm;
  rec_addr_t  slot_addr;
  logic       can_close, can_store;
  logic       we;
  rec_addr_t  waddr;
  logic [7:0] wdata;
  logic       rd_in_range;

  assign item_i.ready = !out_valid_q || result_o.ready;
  assign acc = item_i.valid && item_i.ready;
  assign rx  = acc && (item_i.action == ActRx);
  assign c   = item_i.rx_byte;
  assign n   = {1'b0, pos_q} + (CharPosW+1)'(1);
  assign rd_in_range = item_i.read_addr < RecAddrW'(RecordSize);

  // Field map uses the kind held before this byte; the newline still closes the last field.
  assign fm        = field_map(kind_q, comma_q);
  assign slot_addr = fm.base + RecAddrW'(idx_q);
  assign can_close = !closed_q && (fm.cap != 4'd0) && (idx_q < fm.cap)
                     && (slot_addr < RecAddrW'(RecordSize));
  assign can_store = !closed_q && (fm.cap != 4'd0) && (idx_q < fm.cap - 4'd1)
                     && (slot_addr < RecAddrW'(RecordSize));

  always_comb begin
    in_sent_d = in_sent_q;
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    kind_d    = kind_q;
    comma_d   = comma_q;
    idx_d     = idx_q;
    closed_d  = closed_q;
    done_d    = 1'b0;
    okind_d   = KIND_NONE;
    we        = 1'b0;
    waddr     = slot_addr;
    wdata     = 8'h00;
    if (rx) begin
      if (!in_sent_q) begin
        if (c == ChDollar) begin
          in_sent_d = 1'b1;
          pos_d     = '0;
          hdr_d     = '0;
          kind_d    = KIND_NONE;
          comma_d   = '0;
          idx_d     = '0;
          closed_d  = 1'b0;
        end
      end else if (n > (CharPosW+1)'(LineLimit - 2)) begin
        // drop an overlong line silently
        in_sent_d = 1'b0;
      end else if (c == ChNewline) begin
        we        = can_close;
        done_d    = 1'b1;
        okind_d   = kind_q;
        in_sent_d = 1'b0;
        pos_d     = '0;
        hdr_d     = '0;
        kind_d    = KIND_NONE;
        comma_d   = '0;
        idx_d     = '0;
        closed_d  = 1'b0;
      end else begin
        pos_d = n[CharPosW-1:0];
        if (n == (CharPosW+1)'(3)) begin
          hdr_d = {c, 8'h00};
        end else if (n == (CharPosW+1)'(4)) begin
          hdr_d = {hdr_q[15:8], c};
        end else if (n == (CharPosW+1)'(5)) begin
          if (hdr_q == HdrGg && c == ChA) begin
            kind_d = KIND_GGA;
          end else if (hdr_q == HdrVt && c == ChG) begin
            kind_d = KIND_VTG;
          end
        end
        if (c == ChComma) begin
          if (!closed_q) begin
            we      = can_close;
            comma_d = (comma_q == 4'd15) ? comma_q : comma_q + 4'd1;
            idx_d   = '0;
          end
        end else if (c == ChStar) begin
          we       = can_close;
          closed_d = 1'b1;
        end else if (n > (CharPosW+1)'(5)) begin
          if (can_store) begin
            we    = 1'b1;
            wdata = c;
            idx_d = idx_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q   <= 1'b0;
      pos_q       <= '0;
      hdr_q       <= '0;
      kind_q      <= KIND_NONE;
      comma_q     <= '0;
      idx_q       <= '0;
      closed_q    <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_sent_q <= in_sent_d;
      pos_q     <= pos_d;
      hdr_q     <= hdr_d;
      kind_q    <= kind_d;
      comma_q   <= comma_d;
      idx_q     <= idx_d;
      closed_q  <= closed_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Record RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && item_i.action == ActRead && rd_in_range) begin
      rd_mem_q <= mem[item_i.read_addr];
    end
  end

  // Result payload: load on accept, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      done_q  <= done_d;
      okind_q <= okind_d;
      rd_ok_q <= (item_i.action == ActRead) && rd_in_range && vld_q[item_i.read_addr];
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.read_data     = rd_ok_q ? rd_mem_q : 8'h00;
  assign result_o.sentence_done = done_q;
  assign result_o.sentence_kind = okind_q;

  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_done_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> result_o.read_data == 8'h00)
    else $error("sentence end carries read data");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd10)
    else $error("field index beyond largest capacity");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> vld_q[$past(waddr)])
    else $error("record write left entry invalid");

  a_write_in_sentence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> in_sent_q && rx)
    else $error("record write outside a sentence");

endmodule
